// File: hw/rtl/ilir_pkg.sv
// Shared types and codes for the indexed list insert/remove block.
package ilir_pkg;

  localparam int unsigned PosW   = 8;
  localparam int unsigned CoordW = 32;
  localparam int unsigned WordW  = 2 * CoordW;
  localparam int unsigned OutCntW = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SH_NONE   = 2'd0,
    SH_INSERT = 2'd1,
    SH_REMOVE = 2'd2,
    SH_ROTATE = 2'd3
  } shift_e;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_POS  = 2'd1,
    SRC_HEAD = 2'd2
  } src_e;

  typedef struct packed {
    shift_e  shift;
    logic    dump_load;
    logic    load;
    status_e status;
    src_e    src;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ins_ok;
    logic rem_ok;
    logic dump_last;
  } stat_t;

endpackage

// File: hw/rtl/ilir_ctrl.sv
// Controller: operation decode, dump sequencing and output valid.
module ilir_ctrl import ilir_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  cmd_t   cmd;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;

  always_comb begin
    cmd         = '0;
    cmd.shift   = SH_NONE;
    cmd.status  = ST_OK;
    cmd.src     = SRC_ZERO;
    state_d     = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd.load = 1'b1;
          cmd.last = 1'b1;
          case (opcode_i)
            OP_INSERT: begin
              if (stat_i.full) begin
                cmd.status = ST_FULL;
              end else if (!stat_i.ins_ok) begin
                cmd.status = ST_INVALID;
              end else begin
                cmd.shift = SH_INSERT;
              end
            end
            OP_REMOVE: begin
              if (stat_i.empty) begin
                cmd.status = ST_EMPTY;
              end else if (!stat_i.rem_ok) begin
                cmd.status = ST_INVALID;
              end else begin
                cmd.shift = SH_REMOVE;
                cmd.src   = SRC_POS;
              end
            end
            OP_DUMP: begin
              if (stat_i.empty) begin
                cmd.status = ST_EMPTY;
              end else begin
                cmd.load      = 1'b0;
                cmd.dump_load = 1'b1;
                state_d       = S_DUMP;
              end
            end
            default: begin
              cmd.status = ST_INVALID;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          cmd.load  = 1'b1;
          cmd.src   = SRC_HEAD;
          cmd.shift = SH_ROTATE;
          cmd.last  = stat_i.dump_last;
          if (stat_i.dump_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// File: hw/rtl/ilir_dpath.sv
// Datapath: shifting cell chain, entry count, dump counter, output register.
module ilir_dpath import ilir_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PosW-1:0]    pos_i,
  input  logic [WordW-1:0]   word_i,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  output logic [1:0]         status_o,
  output logic [WordW-1:0]   word_o,
  output logic [OutCntW-1:0] count_o,
  output logic               last_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = PosW + 1;

  logic [WordW-1:0]   cell_q [CAPACITY];
  logic [WordW-1:0]   cell_d [CAPACITY];
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    remain_q, remain_d;
  logic [WordW-1:0]   picked;
  logic [WordW-1:0]   sel_word;
  logic [1:0]         status_q;
  logic [WordW-1:0]   word_q;
  logic [OutCntW-1:0] ocount_q;
  logic               last_q;

  assign stat_o.full      = (count_q == CntW'(CAPACITY));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.ins_ok    = ({1'b0, pos_i} <= CmpW'(count_q));
  assign stat_o.rem_ok    = ({1'b0, pos_i} <  CmpW'(count_q));
  assign stat_o.dump_last = (remain_q == CntW'(1));

  // Pick the entry at the requested position.
  always_comb begin
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_i == PosW'(i)) begin
        picked = picked | cell_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
      case (cmd_i.shift)
        SH_INSERT: begin
          if (pos_i == PosW'(i)) begin
            cell_d[i] = word_i;
          end else if (i > 0 && PosW'(i) > pos_i) begin
            cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
          end
        end
        SH_REMOVE: begin
          if (i < CAPACITY - 1 && PosW'(i) >= pos_i) begin
            cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
        SH_ROTATE: begin
          if (CntW'(i + 1) == count_q) begin
            cell_d[i] = cell_q[0];
          end else if (i < CAPACITY - 1) begin
            cell_d[i] = cell_q[(i < CAPACITY - 1) ? i + 1 : i];
          end
        end
        default: begin
          cell_d[i] = cell_q[i];
        end
      endcase
    end
  end

  always_comb begin
    case (cmd_i.shift)
      SH_INSERT: count_d = count_q + CntW'(1);
      SH_REMOVE: count_d = count_q - CntW'(1);
      default:   count_d = count_q;
    endcase
  end

  always_comb begin
    if (cmd_i.dump_load) begin
      remain_d = count_q;
    end else if (cmd_i.shift == SH_ROTATE) begin
      remain_d = remain_q - CntW'(1);
    end else begin
      remain_d = remain_q;
    end
  end

  always_comb begin
    case (cmd_i.src)
      SRC_POS:  sel_word = picked;
      SRC_HEAD: sel_word = cell_q[0];
      default:  sel_word = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      remain_q <= '0;
    end else begin
      count_q  <= count_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_q[i] <= cell_d[i];
    end
    if (cmd_i.load) begin
      status_q <= cmd_i.status;
      word_q   <= sel_word;
      ocount_q <= OutCntW'(count_d);
      last_q   <= cmd_i.last;
    end
  end

  assign status_o = status_q;
  assign word_o   = word_q;
  assign count_o  = ocount_q;
  assign last_o   = last_q;

endmodule

// File: hw/rtl/indexed_list_insert_remove.sv
// Top level of the indexed list insert/remove block.
// Bounded ordered list of up to CAPACITY point pairs held in a shifting
// cell chain. Insert, remove and rejected operations are each accepted
// and give one result in the next cycle; a new item is taken as soon
// as the output register is empty or being read. A dump of a non-empty list
// rotates the chain once per result, giving count results at one per cycle
// while the output is read, and accepts no item until the last result
// is loaded. Entry x sits in bits 31:0 of a cell and y in bits 63:32.
// The count reported is the count after the operation, taken modulo 32.
module indexed_list_insert_remove import ilir_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[1:0], position[9:2], coord_x[41:10], coord_y[73:42], zero fill
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], out_x[33:2], out_y[65:34], entry_count[70:66], zero fill
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  cmd_t               cmd;
  stat_t              stat;
  logic [1:0]         status;
  logic [WordW-1:0]   word;
  logic [OutCntW-1:0] count;

  ilir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tdata[1:0]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ilir_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pos_i    (s_axis_tdata[9:2]),
    .word_i   ({s_axis_tdata[73:42], s_axis_tdata[41:10]}),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .status_o (status),
    .word_o   (word),
    .count_o  (count),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, count, word, status};

  a_single_result_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != OP_DUMP) |=> m_axis_tvalid)
    else $error("insert/remove result missing");

  a_burst_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[1:0] == ST_OK))
    else $error("non-final result without ok status");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (CAPACITY >= 32 || m_axis_tdata[70:66] <= OutCntW'(CAPACITY)))
    else $error("entry count above capacity");

endmodule
